// ===== rtl/mer_pkg.sv =====
// Shared types and constants of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  localparam int CoordBits = 12;
  localparam int RadBits   = CoordBits - 1;       // half-axis
  localparam int SqBits    = 2 * RadBits;         // rx^2, ry^2
  localparam int TermBits  = 3 * CoordBits;       // 2*ry^2*x, 2*rx^2*y
  localparam int DecBits   = 4 * CoordBits;       // midpoint decision
  localparam int MulBits   = 2 * CoordBits + 2;   // multiplier operand, holds (2x+1)^2
  localparam int ProdBits  = 2 * MulBits;
  localparam int AccBits   = ProdBits;            // quarter-unit accumulator

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2,
    PH_DONE
  } phase_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_RX,
    ST_LD_RY,
    ST_LD_RXRY,
    ST_LD_INIT,
    ST_LD_RND,
    ST_CHECK,
    ST_S_A2,
    ST_S_RYA,
    ST_S_B2,
    ST_S_RXB,
    ST_S_RXRY,
    ST_S_SUB,
    ST_S_RND,
    ST_STEP,
    ST_DEC,
    ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RX2,
    OP_RY2,
    OP_INIT,
    OP_ROUND,
    OP_ROUND_R2,
    OP_ACC_SET,
    OP_ACC_ADD4,
    OP_ACC_SUB4,
    OP_STEP,
    OP_DEC,
    OP_DONE,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RX2_RY,
    MUL_A_A,
    MUL_RY2_P,
    MUL_B_B,
    MUL_RX2_P,
    MUL_RX2_RY2
  } mul_sel_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e mul;
  } ctrl_t;

  typedef struct packed {
    phase_e phase;
    logic   step_lt;   // 2*ry^2*x < 2*rx^2*y
    logic   y_zero;
    logic   out_busy;  // result register full and not taken this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/mer_mul.sv =====
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module mer_mul (
  input  wire logic                          clk_i,
  input  wire logic [mer_pkg::MulBits-1:0]   op_a_i,
  input  wire logic [mer_pkg::MulBits-1:0]   op_b_i,
  output logic      [mer_pkg::ProdBits-1:0]  prod_o
);

  logic [mer_pkg::ProdBits-1:0] prod_q;
  logic [mer_pkg::ProdBits-1:0] prod_d;

  assign prod_d = mer_pkg::ProdBits'(op_a_i) * mer_pkg::ProdBits'(op_b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== rtl/mer_ctrl.sv =====
// Sequencer of the ellipse rasterizer: load, region switch and step sequences.
`timescale 1ns / 1ps
`default_nettype none

module mer_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           cmd_i,
  output logic                in_ready_o,
  input  wire mer_pkg::sts_t  sts_i,
  output mer_pkg::ctrl_t      ctrl_o
);

  mer_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mer_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mer_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == mer_pkg::CMD_LOAD) begin
            state_d = mer_pkg::ST_LD_RX;
          end else if (sts_i.phase inside {mer_pkg::PH_R1, mer_pkg::PH_R2}) begin
            state_d = mer_pkg::ST_STEP;
          end
        end
      end
      mer_pkg::ST_LD_RX:   state_d = mer_pkg::ST_LD_RY;
      mer_pkg::ST_LD_RY:   state_d = mer_pkg::ST_LD_RXRY;
      mer_pkg::ST_LD_RXRY: state_d = mer_pkg::ST_LD_INIT;
      mer_pkg::ST_LD_INIT: state_d = mer_pkg::ST_LD_RND;
      mer_pkg::ST_LD_RND:  state_d = mer_pkg::ST_CHECK;
      mer_pkg::ST_CHECK: begin
        if (sts_i.step_lt || sts_i.y_zero) begin
          state_d = mer_pkg::ST_EMIT;
        end else begin
          state_d = mer_pkg::ST_S_A2;
        end
      end
      mer_pkg::ST_S_A2:   state_d = mer_pkg::ST_S_RYA;
      mer_pkg::ST_S_RYA:  state_d = mer_pkg::ST_S_B2;
      mer_pkg::ST_S_B2:   state_d = mer_pkg::ST_S_RXB;
      mer_pkg::ST_S_RXB:  state_d = mer_pkg::ST_S_RXRY;
      mer_pkg::ST_S_RXRY: state_d = mer_pkg::ST_S_SUB;
      mer_pkg::ST_S_SUB:  state_d = mer_pkg::ST_S_RND;
      mer_pkg::ST_S_RND:  state_d = mer_pkg::ST_EMIT;
      mer_pkg::ST_STEP:   state_d = mer_pkg::ST_DEC;
      mer_pkg::ST_DEC: begin
        state_d = (sts_i.phase == mer_pkg::PH_R1) ? mer_pkg::ST_CHECK : mer_pkg::ST_EMIT;
      end
      mer_pkg::ST_EMIT: begin
        if (!sts_i.out_busy) begin
          state_d = mer_pkg::ST_IDLE;
        end
      end
      default: state_d = mer_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    ctrl_o.op  = mer_pkg::OP_NONE;
    ctrl_o.mul = mer_pkg::MUL_NONE;
    case (state_q)
      mer_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (cmd_i == mer_pkg::CMD_LOAD)) begin
          ctrl_o.op = mer_pkg::OP_LOAD;
        end
      end
      mer_pkg::ST_LD_RX: ctrl_o.mul = mer_pkg::MUL_RX_RX;
      mer_pkg::ST_LD_RY: begin
        ctrl_o.op  = mer_pkg::OP_RX2;
        ctrl_o.mul = mer_pkg::MUL_RY_RY;
      end
      mer_pkg::ST_LD_RXRY: begin
        ctrl_o.op  = mer_pkg::OP_RY2;
        ctrl_o.mul = mer_pkg::MUL_RX2_RY;
      end
      mer_pkg::ST_LD_INIT: ctrl_o.op = mer_pkg::OP_INIT;
      mer_pkg::ST_LD_RND:  ctrl_o.op = mer_pkg::OP_ROUND;
      mer_pkg::ST_CHECK: begin
        if (!sts_i.step_lt && sts_i.y_zero) begin
          ctrl_o.op = mer_pkg::OP_DONE;
        end
      end
      mer_pkg::ST_S_A2:  ctrl_o.mul = mer_pkg::MUL_A_A;
      mer_pkg::ST_S_RYA: ctrl_o.mul = mer_pkg::MUL_RY2_P;
      mer_pkg::ST_S_B2: begin
        ctrl_o.op  = mer_pkg::OP_ACC_SET;
        ctrl_o.mul = mer_pkg::MUL_B_B;
      end
      mer_pkg::ST_S_RXB: ctrl_o.mul = mer_pkg::MUL_RX2_P;
      mer_pkg::ST_S_RXRY: begin
        ctrl_o.op  = mer_pkg::OP_ACC_ADD4;
        ctrl_o.mul = mer_pkg::MUL_RX2_RY2;
      end
      mer_pkg::ST_S_SUB: ctrl_o.op = mer_pkg::OP_ACC_SUB4;
      mer_pkg::ST_S_RND: ctrl_o.op = mer_pkg::OP_ROUND_R2;
      mer_pkg::ST_STEP:  ctrl_o.op = mer_pkg::OP_STEP;
      mer_pkg::ST_DEC:   ctrl_o.op = mer_pkg::OP_DEC;
      mer_pkg::ST_EMIT: begin
        if (!sts_i.out_busy) begin
          ctrl_o.op = mer_pkg::OP_EMIT;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mer_dpath.sv =====
// Ellipse datapath: geometry registers, decision accumulator, result register.
`timescale 1ns / 1ps
`default_nettype none

module mer_dpath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire mer_pkg::ctrl_t                 ctrl_i,
  output mer_pkg::sts_t                       sts_o,
  input  wire logic [mer_pkg::CoordBits-1:0]  start_x_i,
  input  wire logic [mer_pkg::CoordBits-1:0]  start_y_i,
  input  wire logic [mer_pkg::CoordBits-1:0]  end_x_i,
  input  wire logic [mer_pkg::CoordBits-1:0]  end_y_i,
  output logic      [mer_pkg::MulBits-1:0]    mul_a_o,
  output logic      [mer_pkg::MulBits-1:0]    mul_b_o,
  input  wire logic [mer_pkg::ProdBits-1:0]   prod_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [mer_pkg::CoordBits-1:0]  pt0_x_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt0_y_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt1_x_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt1_y_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt2_x_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt2_y_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt3_x_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt3_y_o,
  output logic                                last_o
);

  localparam int CB = mer_pkg::CoordBits;
  localparam int RB = mer_pkg::RadBits;
  localparam int SB = mer_pkg::SqBits;
  localparam int TB = mer_pkg::TermBits;
  localparam int DB = mer_pkg::DecBits;
  localparam int AB = mer_pkg::AccBits;
  localparam int MB = mer_pkg::MulBits;

  logic [CB-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [RB-1:0] rx_q, rx_d, ry_q, ry_d;
  logic [SB-1:0] rx2_q, rx2_d, ry2_q, ry2_d;
  logic [CB-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [TB-1:0] stepx_q, stepx_d, stepy_q, stepy_d;
  logic [DB-1:0] dec_q, dec_d;
  logic [AB-1:0] acc_q, acc_d;
  logic          simple_q, simple_d;
  mer_pkg::phase_e phase_q, phase_d;
  logic          out_valid_q, out_valid_d;
  logic [CB-1:0] pt_px_q, pt_px_d, pt_mx_q, pt_mx_d, pt_py_q, pt_py_d, pt_my_q, pt_my_d;
  logic          out_last_q, out_last_d;

  logic [CB-1:0] diff_x, diff_y;
  logic [CB:0]   sum_x, sum_y;
  logic [TB-1:0] two_rx2, two_ry2;
  logic [AB-1:0] prod4, rnd_t, rnd_u;
  logic [CB-1:0] y_m1;
  logic          dec_neg, dec_pos;

  // box corners to center and half axes
  assign diff_x = (end_x_i >= start_x_i) ? (end_x_i - start_x_i) : (start_x_i - end_x_i);
  assign diff_y = (end_y_i >= start_y_i) ? (end_y_i - start_y_i) : (start_y_i - end_y_i);
  assign sum_x  = {1'b0, start_x_i} + {1'b0, end_x_i};
  assign sum_y  = {1'b0, start_y_i} + {1'b0, end_y_i};

  assign two_rx2 = TB'(rx2_q) << 1;
  assign two_ry2 = TB'(ry2_q) << 1;
  assign prod4   = {prod_i[AB-3:0], 2'b00};
  assign y_m1    = cur_y_q - CB'(1);
  assign dec_neg = dec_q[DB-1];
  assign dec_pos = !dec_q[DB-1] && (|dec_q);

  // (q + 2) / 4 truncated toward zero
  assign rnd_t = acc_q + AB'(2);
  assign rnd_u = rnd_t[AB-1] ? (rnd_t + AB'(3)) : rnd_t;

  always_comb begin
    mul_a_o = '0;
    mul_b_o = '0;
    case (ctrl_i.mul)
      mer_pkg::MUL_RX_RX: begin
        mul_a_o = MB'(rx_q);
        mul_b_o = MB'(rx_q);
      end
      mer_pkg::MUL_RY_RY: begin
        mul_a_o = MB'(ry_q);
        mul_b_o = MB'(ry_q);
      end
      mer_pkg::MUL_RX2_RY: begin
        mul_a_o = MB'(rx2_q);
        mul_b_o = MB'(ry_q);
      end
      mer_pkg::MUL_A_A: begin
        mul_a_o = MB'({cur_x_q, 1'b1});
        mul_b_o = MB'({cur_x_q, 1'b1});
      end
      mer_pkg::MUL_RY2_P: begin
        mul_a_o = MB'(ry2_q);
        mul_b_o = prod_i[MB-1:0];
      end
      mer_pkg::MUL_B_B: begin
        mul_a_o = MB'(y_m1);
        mul_b_o = MB'(y_m1);
      end
      mer_pkg::MUL_RX2_P: begin
        mul_a_o = MB'(rx2_q);
        mul_b_o = prod_i[MB-1:0];
      end
      mer_pkg::MUL_RX2_RY2: begin
        mul_a_o = MB'(rx2_q);
        mul_b_o = MB'(ry2_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    cx_d = cx_q;  cy_d = cy_q;
    rx_d = rx_q;  ry_d = ry_q;
    rx2_d = rx2_q;  ry2_d = ry2_q;
    cur_x_d = cur_x_q;  cur_y_d = cur_y_q;
    stepx_d = stepx_q;  stepy_d = stepy_q;
    dec_d = dec_q;
    acc_d = acc_q;
    simple_d = simple_q;
    phase_d = phase_q;
    pt_px_d = pt_px_q;  pt_mx_d = pt_mx_q;
    pt_py_d = pt_py_q;  pt_my_d = pt_my_q;
    out_last_d = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (ctrl_i.op)
      mer_pkg::OP_LOAD: begin
        cx_d = sum_x[CB:1];
        cy_d = sum_y[CB:1];
        rx_d = diff_x[CB-1:1];
        ry_d = diff_y[CB-1:1];
      end
      mer_pkg::OP_RX2: rx2_d = prod_i[SB-1:0];
      mer_pkg::OP_RY2: ry2_d = prod_i[SB-1:0];
      mer_pkg::OP_INIT: begin
        cur_x_d = '0;
        cur_y_d = CB'(ry_q);
        stepx_d = '0;
        stepy_d = {prod_i[TB-2:0], 1'b0};
        acc_d   = (AB'(ry2_q) << 2) - prod4 + AB'(rx2_q);
        phase_d = mer_pkg::PH_R1;
      end
      mer_pkg::OP_ROUND: dec_d = rnd_u[DB+1:2];
      mer_pkg::OP_ROUND_R2: begin
        dec_d   = rnd_u[DB+1:2];
        phase_d = mer_pkg::PH_R2;
      end
      mer_pkg::OP_ACC_SET:  acc_d = prod_i[AB-1:0];
      mer_pkg::OP_ACC_ADD4: acc_d = acc_q + prod4;
      mer_pkg::OP_ACC_SUB4: acc_d = acc_q - prod4;
      mer_pkg::OP_STEP: begin
        if (phase_q == mer_pkg::PH_R1) begin
          simple_d = dec_neg;
          cur_x_d  = cur_x_q + CB'(1);
          stepx_d  = stepx_q + two_ry2;
          if (!dec_neg) begin
            cur_y_d = y_m1;
            stepy_d = stepy_q - two_rx2;
          end
        end else begin
          simple_d = dec_pos;
          cur_y_d  = y_m1;
          stepy_d  = stepy_q - two_rx2;
          if (!dec_pos) begin
            cur_x_d = cur_x_q + CB'(1);
            stepx_d = stepx_q + two_ry2;
          end
        end
      end
      mer_pkg::OP_DEC: begin
        if (phase_q == mer_pkg::PH_R1) begin
          dec_d = dec_q + DB'(ry2_q) + DB'(stepx_q) - (simple_q ? DB'(0) : DB'(stepy_q));
        end else begin
          dec_d = dec_q + DB'(rx2_q) - DB'(stepy_q) + (simple_q ? DB'(0) : DB'(stepx_q));
          if (cur_y_q == '0) begin
            phase_d = mer_pkg::PH_DONE;
          end
        end
      end
      mer_pkg::OP_DONE: phase_d = mer_pkg::PH_DONE;
      mer_pkg::OP_EMIT: begin
        pt_px_d     = cx_q + cur_x_q;
        pt_mx_d     = cx_q - cur_x_q;
        pt_py_d     = cy_q + cur_y_q;
        pt_my_d     = cy_q - cur_y_q;
        out_last_d  = (phase_q == mer_pkg::PH_DONE);
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mer_pkg::PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;  cy_q <= cy_d;
    rx_q <= rx_d;  ry_q <= ry_d;
    rx2_q <= rx2_d;  ry2_q <= ry2_d;
    cur_x_q <= cur_x_d;  cur_y_q <= cur_y_d;
    stepx_q <= stepx_d;  stepy_q <= stepy_d;
    dec_q <= dec_d;
    acc_q <= acc_d;
    simple_q <= simple_d;
    pt_px_q <= pt_px_d;  pt_mx_q <= pt_mx_d;
    pt_py_q <= pt_py_d;  pt_my_q <= pt_my_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.phase    = phase_q;
  assign sts_o.step_lt  = (stepx_q < stepy_q);
  assign sts_o.y_zero   = (cur_y_q == '0);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign pt0_x_o = pt_px_q;
  assign pt0_y_o = pt_py_q;
  assign pt1_x_o = pt_mx_q;
  assign pt1_y_o = pt_py_q;
  assign pt2_x_o = pt_px_q;
  assign pt2_y_o = pt_my_q;
  assign pt3_x_o = pt_mx_q;
  assign pt3_y_o = pt_my_q;
  assign last_o  = out_last_q;

  // a result is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == mer_pkg::OP_EMIT) |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == mer_pkg::OP_EMIT) |=>
      (out_valid_q && (out_last_q == (phase_q == mer_pkg::PH_DONE))))
    else $error("last flag does not match phase");

  a_r2_y_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == mer_pkg::OP_STEP && phase_q == mer_pkg::PH_R2) |-> (cur_y_q != '0))
    else $error("region 2 step with y at zero");

  a_no_skip_r1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == mer_pkg::PH_IDLE) |=> (phase_q != mer_pkg::PH_R2))
    else $error("region 2 entered without load");

endmodule

`default_nettype wire

// ===== rtl/midpoint_ellipse_rasterizer.sv =====
// Top level of the midpoint ellipse rasterizer.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o  cmd_i, start_x_i, start_y_i, end_x_i, end_y_i
//   out      output     out_valid_o / out_ready_i pt0..pt3 x/y, last_o
//
// Load transaction: the shared multiplier runs rx^2, ry^2, rx^2*ry in turn, the decision
// is set and rounded, and the region switch follows if the ellipse starts in region 2.
// Step transaction: a step and a decision update, then in region 1 a region check; at the
// region switch the region-2 start value takes five passes through the multiplier.
// One transaction at a time; the result register frees the input side while a
// result waits, and the sequencer holds before writing a new result until taken.
// Reset clears the sequencer, phase and result valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_rasterizer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           cmd_i,
  input  wire logic [mer_pkg::CoordBits-1:0]  start_x_i,
  input  wire logic [mer_pkg::CoordBits-1:0]  start_y_i,
  input  wire logic [mer_pkg::CoordBits-1:0]  end_x_i,
  input  wire logic [mer_pkg::CoordBits-1:0]  end_y_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [mer_pkg::CoordBits-1:0]  pt0_x_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt0_y_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt1_x_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt1_y_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt2_x_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt2_y_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt3_x_o,
  output logic      [mer_pkg::CoordBits-1:0]  pt3_y_o,
  output logic                                last_o
);

  mer_pkg::ctrl_t ctrl;
  mer_pkg::sts_t  sts;
  logic [mer_pkg::MulBits-1:0]  mul_a, mul_b;
  logic [mer_pkg::ProdBits-1:0] prod;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctrl_o     (ctrl)
  );

  mer_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  mer_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .sts_o       (sts),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .prod_i      (prod),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pt0_x_o     (pt0_x_o),
    .pt0_y_o     (pt0_y_o),
    .pt1_x_o     (pt1_x_o),
    .pt1_y_o     (pt1_y_o),
    .pt2_x_o     (pt2_x_o),
    .pt2_y_o     (pt2_y_o),
    .pt3_x_o     (pt3_x_o),
    .pt3_y_o     (pt3_y_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb_midpoint_ellipse_rasterizer.sv =====
// Testbench for midpoint_ellipse_rasterizer: directed and random ellipse walks against a predictor.
`timescale 1ns / 1ps

module tb_midpoint_ellipse_rasterizer;

  localparam int CB = mer_pkg::CoordBits;
  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    logic [3:0][CB-1:0] px;
    logic [3:0][CB-1:0] py;
    logic               last;
  } points_t;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   cmd_i       = mer_pkg::CMD_LOAD;
  coord_t start_x_i   = '0;
  coord_t start_y_i   = '0;
  coord_t end_x_i     = '0;
  coord_t end_y_i     = '0;
  logic   out_ready_i = 1'b0;
  logic   in_ready_o;
  logic   out_valid_o;
  coord_t pt0_x_o, pt0_y_o, pt1_x_o, pt1_y_o;
  coord_t pt2_x_o, pt2_y_o, pt3_x_o, pt3_y_o;
  logic   last_o;

  midpoint_ellipse_rasterizer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pt0_x_o     (pt0_x_o),
    .pt0_y_o     (pt0_y_o),
    .pt1_x_o     (pt1_x_o),
    .pt1_y_o     (pt1_y_o),
    .pt2_x_o     (pt2_x_o),
    .pt2_y_o     (pt2_y_o),
    .pt3_x_o     (pt3_x_o),
    .pt3_y_o     (pt3_y_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted ellipse walk state
  coord_t ctr_x = '0, ctr_y = '0;
  longint rx_sq = 0, ry_sq = 0;
  longint off_x = 0, off_y = 0;
  longint term_x = 0, term_y = 0;
  longint dvar = 0;
  mer_pkg::phase_e walk_ph = mer_pkg::PH_IDLE;

  points_t pts_due_q[$];

  int  n_errors = 0;
  int  n_loads = 0, n_advances = 0, n_ignored = 0;
  int  n_results = 0, n_checked = 0, n_finished = 0;
  int  stall_left = 0;
  bit  no_idle = 1'b0;

  // Quarter-unit value rounded as (v + 0.5) truncated toward zero
  function automatic longint round_q(input longint q);
    return (q + 2) / 4;
  endfunction

  // After a region-1 position: stay, enter region 2, or finish
  function automatic void settle_region();
    longint a, b;
    if (walk_ph == mer_pkg::PH_R1 && term_x < term_y) return;
    if (off_y > 0) begin
      a = 2 * off_x + 1;
      b = off_y - 1;
      dvar = round_q(ry_sq * a * a + 4 * rx_sq * b * b - 4 * rx_sq * ry_sq);
      walk_ph = mer_pkg::PH_R2;
    end else begin
      walk_ph = mer_pkg::PH_DONE;
    end
  endfunction

  function automatic bit rasterize(input logic cmd, input coord_t sx, sy, ex, ey,
                                   output points_t pts);
    longint dx, dy, rx, ry;
    pts = '0;
    if (cmd == mer_pkg::CMD_LOAD) begin
      dx = longint'(ex) - longint'(sx);
      dy = longint'(ey) - longint'(sy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      rx = dx / 2;
      ry = dy / 2;
      ctr_x = coord_t'((longint'(sx) + longint'(ex)) / 2);
      ctr_y = coord_t'((longint'(sy) + longint'(ey)) / 2);
      rx_sq = rx * rx;
      ry_sq = ry * ry;
      off_x = 0;
      off_y = ry;
      term_x = 0;
      term_y = 2 * rx_sq * ry;
      dvar = round_q(4 * ry_sq - 4 * rx_sq * ry + rx_sq);
      walk_ph = mer_pkg::PH_R1;
      settle_region();
    end else if (walk_ph == mer_pkg::PH_R1) begin
      off_x++;
      term_x += 2 * ry_sq;
      if (dvar < 0) begin
        dvar += ry_sq + term_x;
      end else begin
        off_y--;
        term_y -= 2 * rx_sq;
        dvar += ry_sq + term_x - term_y;
      end
      settle_region();
    end else if (walk_ph == mer_pkg::PH_R2) begin
      off_y--;
      term_y -= 2 * rx_sq;
      if (dvar > 0) begin
        dvar += rx_sq - term_y;
      end else begin
        off_x++;
        term_x += 2 * ry_sq;
        dvar += rx_sq - term_y + term_x;
      end
      if (off_y <= 0) walk_ph = mer_pkg::PH_DONE;
    end else begin
      return 1'b0;
    end
    pts.px[0] = coord_t'(longint'(ctr_x) + off_x);
    pts.py[0] = coord_t'(longint'(ctr_y) + off_y);
    pts.px[1] = coord_t'(longint'(ctr_x) - off_x);
    pts.py[1] = coord_t'(longint'(ctr_y) + off_y);
    pts.px[2] = coord_t'(longint'(ctr_x) + off_x);
    pts.py[2] = coord_t'(longint'(ctr_y) - off_y);
    pts.px[3] = coord_t'(longint'(ctr_x) - off_x);
    pts.py[3] = coord_t'(longint'(ctr_y) - off_y);
    pts.last  = (walk_ph == mer_pkg::PH_DONE);
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with valid
  // still high, so a following send keeps it up without a low pulse.
  task automatic send_item(input logic cmd, input coord_t sx, sy, ex, ey);
    points_t want;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (rasterize(cmd, sx, sy, ex, ey, want)) begin
      pts_due_q = {pts_due_q, want};
      n_results++;
    end else begin
      n_ignored++;
    end
    if (cmd == mer_pkg::CMD_LOAD) n_loads++;
    else n_advances++;
    @(negedge clk_i);
  endtask

  task automatic send_load(input int sx, sy, ex, ey);
    send_item(mer_pkg::CMD_LOAD, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
  endtask

  // Corner fields carry noise on an advance; the block must ignore them
  task automatic send_advance();
    send_item(mer_pkg::CMD_STEP, coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic walk_to_done(input int max_steps);
    int k;
    k = 0;
    while ((walk_ph == mer_pkg::PH_R1 || walk_ph == mer_pkg::PH_R2) && k < max_steps) begin
      send_advance();
      k++;
    end
  endtask

  // Sender goes quiet until every predicted result has been taken
  task automatic wait_all_points();
    in_valid_i <= 1'b0;
    while (pts_due_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic test_idle_advance();
    send_advance();
    send_advance();
    wait_all_points();
  endtask

  task automatic test_small_walk();
    send_load(100, 200, 104, 202);
    walk_to_done(100);
    send_advance();
  endtask

  task automatic test_degenerate();
    send_load(0, 0, 0, 0);
    send_load(300, 40, 10, 41);    // flat height
    send_advance();
    send_load(50, 60, 51, 70);     // zero width, straight into region 2
    walk_to_done(100);
    send_advance();
  endtask

  task automatic test_extremes();
    send_load(0, 0, 4095, 4095);
    walk_to_done(3);
    send_load(4095, 4095, 0, 0);   // restart mid-walk
    walk_to_done(2);
    send_load(4095, 0, 0, 4095);
    walk_to_done(2);
    send_load(0, 4095, 4095, 0);
    wait_all_points();
  endtask

  task automatic pick_corners(output int sx, sy, ex, ey, output bit big);
    int span, r;
    r = $urandom_range(0, 99);
    span = (r < 85) ? 40 : (r < 97) ? 300 : 4095;
    big = (span == 4095);
    sx = $urandom_range(0, 4095);
    sy = $urandom_range(0, 4095);
    ex = $urandom_range(0, 1) ? sx + $urandom_range(0, span) : sx - $urandom_range(0, span);
    ey = $urandom_range(0, 1) ? sy + $urandom_range(0, span) : sy - $urandom_range(0, span);
    r = $urandom_range(0, 19);
    if (r == 0) ey = sy + $urandom_range(0, 1);
    if (r == 1) ex = sx + $urandom_range(0, 1);
    if (ex > 4095) ex = 4095;
    if (ex < 0) ex = 0;
    if (ey > 4095) ey = 4095;
    if (ey < 0) ey = 0;
  endtask

  task automatic run_random_ellipses(input int target);
    int sx, sy, ex, ey, r;
    bit big;
    while (n_results < target) begin
      pick_corners(sx, sy, ex, ey, big);
      send_load(sx, sy, ex, ey);
      r = $urandom_range(0, 99);
      if (big) begin
        walk_to_done($urandom_range(20, 80));
      end else if (r < 75) begin
        walk_to_done(100000);
        repeat ($urandom_range(0, 2)) send_advance();
      end else begin
        walk_to_done($urandom_range(0, 30));
      end
      if (!no_idle && $urandom_range(0, 29) == 0) wait_all_points();
    end
  endtask

  task automatic test_random_walks();
    run_random_ellipses(n_results + 1000);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    run_random_ellipses(n_results + 200);
  endtask

  // Receiver stalls in bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_points
    points_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.px   = {pt3_x_o, pt2_x_o, pt1_x_o, pt0_x_o};
      got.py   = {pt3_y_o, pt2_y_o, pt1_y_o, pt0_y_o};
      got.last = last_o;
      if (got.last === 1'b1) n_finished++;
      if (pts_due_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        want = pts_due_q.pop_front();
        n_checked++;
        for (int i = 0; i < 4; i++) begin
          if (got.px[i] !== want.px[i] || got.py[i] !== want.py[i]) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result %0d pt%0d: expected (%0d,%0d) got (%0d,%0d)", n_checked, i,
                       want.px[i], want.py[i], got.px[i], got.py[i]);
          end
        end
        if (got.last !== want.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("result %0d last: expected %0b got %0b", n_checked, want.last, got.last);
        end
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_idle_advance();
    test_small_walk();
    test_degenerate();
    test_extremes();
    test_random_walks();
    test_back_to_back();
    wait_all_points();
    if (pts_due_q.size() != 0) begin
      n_errors++;
      $display("%0d expected results never arrived", pts_due_q.size());
    end
    $display("Ran %0d loads and %0d advances (%0d with no output), %0d ellipses completed,",
             n_loads, n_advances, n_ignored, n_finished);
    $display("%0d point sets checked with random input gaps and output stalls", n_checked);
    if (n_errors == 0) begin
      $display("** midpoint_ellipse_rasterizer: PASSED **");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("** midpoint_ellipse_rasterizer: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pts_due_q.size());
    $display("** midpoint_ellipse_rasterizer: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mer_pkg.sv
rtl/mer_mul.sv
rtl/mer_ctrl.sv
rtl/mer_dpath.sv
rtl/midpoint_ellipse_rasterizer.sv
bench/tb_midpoint_ellipse_rasterizer.sv
